// ===== src/distributed_mutex_node_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the mutex node modules
// ----------------------------------------------------------------------------
`ifndef DISTRIBUTED_MUTEX_NODE_UNIT_DEFINES_SVH
`define DISTRIBUTED_MUTEX_NODE_UNIT_DEFINES_SVH

// same-cycle implication
`define DMN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DMN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dmn_pkg.sv =====
// ----------------------------------------------------------------------------
// dmn_pkg
// Types and codes shared by the mutual exclusion node modules.
// ----------------------------------------------------------------------------
package dmn_pkg;

   localparam int OP_W       = 2;
   localparam int ACT_W      = 2;
   localparam int NODE_W     = 4;
   localparam int PCLK_W     = 32;
   localparam int LOCK_W     = 16;
   localparam int RANK_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // event codes
   localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
   localparam logic [OP_W-1:0] OP_REPLY   = 2'd1;
   localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd2;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

   // result codes
   localparam logic [ACT_W-1:0] ACT_REPLY     = 2'd0;
   localparam logic [ACT_W-1:0] ACT_BROADCAST = 2'd1;
   localparam logic [ACT_W-1:0] ACT_GRANT     = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_RANK   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_ID    = 2'd2;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic take;    // apply the accepted event
      logic grant;   // emit a pending grant
      logic drain;   // emit the lowest deferred reply
   } dmn_cmd_type;

   typedef struct packed {
      logic slot_free;   // result register can load this cycle
      logic map_empty;   // no deferred replies
      logic map_last;    // at most one deferred reply left
      logic solo;        // only this node takes part
   } dmn_status_type;

endpackage

// ===== src/dmn_ifs.sv =====
// ----------------------------------------------------------------------------
// dmn_req_if / dmn_rsp_if
// Valid/ready channels for protocol events and emitted packets.
// ----------------------------------------------------------------------------
interface dmn_req_if import dmn_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [NODE_W-1:0] source_node;
   logic [PCLK_W-1:0] packet_clock;

   modport source (output valid, operation, source_node, packet_clock, input ready);
   modport sink   (input valid, operation, source_node, packet_clock, output ready);
endinterface

interface dmn_rsp_if import dmn_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [NODE_W-1:0] dest_node;
   logic [PCLK_W-1:0] clock_stamp;
   logic [LOCK_W-1:0] packet_lock;
   logic              last;

   modport source (output valid, action, dest_node, clock_stamp, packet_lock, last,
                   input ready);
   modport sink   (input valid, action, dest_node, clock_stamp, packet_lock, last,
                   output ready);
endinterface

// ===== src/dmn_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmn_ctrl
// Sequencer: takes events, then issues the extra grant after a lone acquire
// and walks the deferred replies after a release.
// ----------------------------------------------------------------------------
`include "distributed_mutex_node_unit_defines.svh"

module dmn_ctrl import dmn_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_operation,
   output logic            req_ready,
   input  dmn_status_type  status,
   output dmn_cmd_type     cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_GRANT = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE) && status.slot_free;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.take = 1'b1;
               if (req_operation == OP_ACQUIRE && status.solo) begin
                  state_in = S_GRANT;
               end else if (req_operation == OP_RELEASE && !status.map_empty) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_GRANT: begin
            if (status.slot_free) begin
               cmd.grant = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_DRAIN: begin
            if (status.slot_free) begin
               cmd.drain = 1'b1;
               if (status.map_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DMN_ASSERT_NOW(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE,
      "request taken outside idle")
   `DMN_ASSERT_NOW(a_load_free, clock, reset, cmd.grant || cmd.drain, status.slot_free,
      "result loaded while register full")
   `DMN_ASSERT_NEXT(a_solo_grant, clock, reset,
      cmd.take && req_operation == OP_ACQUIRE && status.solo, state_ff == S_GRANT,
      "lone acquire not followed by grant")

endmodule

// ===== src/dmn_dp.sv =====
// ----------------------------------------------------------------------------
// dmn_dp
// Datapath: configuration, protocol state, deferred-reply map and the
// result register.
// ----------------------------------------------------------------------------
`include "distributed_mutex_node_unit_defines.svh"

module dmn_dp import dmn_pkg::*; #(
   parameter int NODES      = 16,
   parameter int CLOCK_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [NODE_W-1:0]     req_source_node,
   input  logic [PCLK_W-1:0]     req_packet_clock,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [ACT_W-1:0]      rsp_action,
   output logic [NODE_W-1:0]     rsp_dest_node,
   output logic [PCLK_W-1:0]     rsp_clock_stamp,
   output logic [LOCK_W-1:0]     rsp_packet_lock,
   output logic                  rsp_last,
   input  dmn_cmd_type           cmd,
   output dmn_status_type        status
);

   localparam int CNT_W = $clog2(NODES + 1);
   localparam int REP_W = $clog2(NODES);
   localparam int IDX_W = $clog2(NODES);
   localparam int CMP_W = CNT_W + NODE_W;

   function automatic logic [PCLK_W-1:0] stamp_of(input logic [CLOCK_BITS-1:0] c);
      logic [63:0] w;
      w = 64'(c);
      return w[PCLK_W-1:0];
   endfunction

   // configuration
   logic [RANK_W-1:0]  own_rank_ff,   own_rank_in;
   logic [COUNT_W-1:0] node_count_ff, node_count_in;
   logic [LOCK_W-1:0]  lock_id_ff,    lock_id_in;

   // protocol state
   logic                  wants_ff,   wants_in;
   logic [CLOCK_BITS-1:0] local_ff,   local_in;
   logic [CLOCK_BITS-1:0] highest_ff, highest_in;
   logic [REP_W-1:0]      replies_ff, replies_in;
   logic [NODES-1:0]      map_ff,     map_in;

   // result register
   logic              valid_ff, valid_in;
   logic [ACT_W-1:0]  act_ff,   act_in;
   logic [NODE_W-1:0] dest_ff,  dest_in;
   logic [PCLK_W-1:0] stamp_ff, stamp_in;
   logic [LOCK_W-1:0] lock_ff,  lock_in;
   logic              last_ff,  last_in;

   logic [CNT_W-1:0]      count;
   logic [63:0]           pclk_wide;
   logic [CLOCK_BITS-1:0] pclk;
   logic [CLOCK_BITS-1:0] next_clock;
   logic                  later;
   logic                  defer;
   logic [NODES-1:0]      low_bit;
   logic [IDX_W-1:0]      low_idx;
   logic                  load;

   // effective node count: zero acts as one, clamp at NODES
   always_comb begin
      if (node_count_ff == '0) begin
         count = CNT_W'(1);
      end else if (8'(node_count_ff) > 8'(NODES)) begin
         count = CNT_W'(NODES);
      end else begin
         count = CNT_W'(node_count_ff);
      end
   end

   always_comb begin
      pclk_wide  = 64'(req_packet_clock);
      pclk       = pclk_wide[CLOCK_BITS-1:0];
      next_clock = (&highest_ff) ? highest_ff : highest_ff + 1'b1;
      later      = (pclk > local_ff) ||
                   ((pclk == local_ff) && (req_source_node > own_rank_ff));
      defer      = wants_ff && later && (req_source_node != own_rank_ff) &&
                   (CMP_W'(req_source_node) < CMP_W'(count));
   end

   // isolate lowest deferred rank and encode it
   always_comb begin
      low_bit = map_ff & (~map_ff + 1'b1);
      low_idx = '0;
      for (int i = 0; i < NODES; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | IDX_W'(i);
         end
      end
   end

   always_comb begin
      status.slot_free = !valid_ff || rsp_ready;
      status.map_empty = (map_ff == '0);
      status.map_last  = ((map_ff & ~low_bit) == '0);
      status.solo      = (count == CNT_W'(1));
   end

   always_comb begin
      own_rank_in   = own_rank_ff;
      node_count_in = node_count_ff;
      lock_id_in    = lock_id_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_OWN_RANK:   own_rank_in   = csr_write_data[RANK_W-1:0];
            CSR_NODE_COUNT: node_count_in = csr_write_data[COUNT_W-1:0];
            CSR_LOCK_ID:    lock_id_in    = csr_write_data[LOCK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      wants_in   = wants_ff;
      local_in   = local_ff;
      highest_in = highest_ff;
      replies_in = replies_ff;
      map_in     = map_ff;
      load       = 1'b0;
      act_in     = act_ff;
      dest_in    = dest_ff;
      stamp_in   = stamp_ff;
      lock_in    = lock_ff;
      last_in    = last_ff;

      if (cmd.take) begin
         case (req_operation)
            OP_REQUEST: begin
               if (pclk > highest_ff) begin
                  highest_in = pclk;
               end
               if (defer) begin
                  map_in = map_ff | (NODES'(1) << req_source_node);
               end else begin
                  load     = 1'b1;
                  act_in   = ACT_REPLY;
                  dest_in  = req_source_node;
                  stamp_in = stamp_of(local_ff);
                  lock_in  = lock_id_ff;
                  last_in  = 1'b1;
               end
            end
            OP_REPLY: begin
               if (replies_ff != '0) begin
                  replies_in = replies_ff - 1'b1;
                  if (replies_ff == REP_W'(1)) begin
                     load     = 1'b1;
                     act_in   = ACT_GRANT;
                     dest_in  = '0;
                     stamp_in = '0;
                     lock_in  = '0;
                     last_in  = 1'b1;
                  end
               end
            end
            OP_ACQUIRE: begin
               wants_in   = 1'b1;
               local_in   = next_clock;
               replies_in = REP_W'(count - 1'b1);
               load       = 1'b1;
               act_in     = ACT_BROADCAST;
               dest_in    = '0;
               stamp_in   = stamp_of(next_clock);
               lock_in    = lock_id_ff;
               last_in    = !status.solo;
            end
            OP_RELEASE: begin
               wants_in   = 1'b0;
               replies_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.grant) begin
         load     = 1'b1;
         act_in   = ACT_GRANT;
         dest_in  = '0;
         stamp_in = '0;
         lock_in  = '0;
         last_in  = 1'b1;
      end

      if (cmd.drain) begin
         load     = 1'b1;
         act_in   = ACT_REPLY;
         dest_in  = NODE_W'(low_idx);
         stamp_in = stamp_of(local_ff);
         lock_in  = lock_id_ff;
         last_in  = status.map_last;
         map_in   = map_ff & ~low_bit;
      end

      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_rank_ff   <= '0;
         node_count_ff <= NODE_COUNT_RESET;
         lock_id_ff    <= '0;
         wants_ff      <= 1'b0;
         local_ff      <= '0;
         highest_ff    <= '0;
         replies_ff    <= '0;
         map_ff        <= '0;
         valid_ff      <= 1'b0;
      end else begin
         own_rank_ff   <= own_rank_in;
         node_count_ff <= node_count_in;
         lock_id_ff    <= lock_id_in;
         wants_ff      <= wants_in;
         local_ff      <= local_in;
         highest_ff    <= highest_in;
         replies_ff    <= replies_in;
         map_ff        <= map_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      dest_ff  <= dest_in;
      stamp_ff <= stamp_in;
      lock_ff  <= lock_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_action      = act_ff;
   assign rsp_dest_node   = dest_ff;
   assign rsp_clock_stamp = stamp_ff;
   assign rsp_packet_lock = lock_ff;
   assign rsp_last        = last_ff;

   `DMN_ASSERT_NOW(a_idle_no_replies, clock, reset, !wants_ff, replies_ff == '0,
      "replies outstanding without an access request")
   `DMN_ASSERT_NEXT(a_drain_empties, clock, reset, cmd.drain && status.map_last,
      map_ff == '0, "deferred map not empty after last reply")
   `DMN_ASSERT_NOW(a_load_slot, clock, reset, load, status.slot_free,
      "result register overwritten")

endmodule

// ===== src/distributed_mutex_node_unit.sv =====
// A result is registered in the cycle after its event is accepted.
// Throughput: one event per cycle while results are taken as they appear.
// Acquire on a lone node holds off new events while its grant is issued;
// release holds off new events while the map walk emits deferred replies one at a time.
// Reset (synchronous): protocol state cleared, rank 0, node count 16, lock 0.
// ----------------------------------------------------------------------------
// distributed_mutex_node_unit
// One node of Ricart-Agrawala mutual exclusion: sequencer plus datapath.
// ----------------------------------------------------------------------------
module distributed_mutex_node_unit import dmn_pkg::*; #(
   parameter int NODES      = 16,
   parameter int CLOCK_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   dmn_req_if.sink               req_ch,
   dmn_rsp_if.source             rsp_ch,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   dmn_cmd_type    cmd;
   dmn_status_type status;

   dmn_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .status        (status),
      .cmd           (cmd)
   );

   dmn_dp #(
      .NODES      (NODES),
      .CLOCK_BITS (CLOCK_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_operation    (req_ch.operation),
      .req_source_node  (req_ch.source_node),
      .req_packet_clock (req_ch.packet_clock),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_action       (rsp_ch.action),
      .rsp_dest_node    (rsp_ch.dest_node),
      .rsp_clock_stamp  (rsp_ch.clock_stamp),
      .rsp_packet_lock  (rsp_ch.packet_lock),
      .rsp_last         (rsp_ch.last),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== bench/tb_distributed_mutex_node_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mutual exclusion node testbench
// Drives protocol events into distributed_mutex_node_unit under random
// back-pressure, predicts the emitted packets and checks each one in order.
// ----------------------------------------------------------------------------
module tb_distributed_mutex_node_unit import dmn_pkg::*; ();

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [NODE_W-1:0] dest;
      logic [PCLK_W-1:0] stamp;
      logic [LOCK_W-1:0] lock;
      logic              last;
   } packet_type;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [NODE_W-1:0] src;
      logic [PCLK_W-1:0] pclk;
      bit                typed;
      packet_type        pkt;
   } row_type;

   typedef struct {
      logic [RANK_W-1:0]  rank;
      logic [COUNT_W-1:0] count;
      logic [LOCK_W-1:0]  lock;
      bit                 wide;
   } phase_type;

   localparam packet_type NO_PACKET = '0;
   localparam logic [PCLK_W-1:0] CLK_MAX = '1;
   localparam int HEAD_ROWS = 18;
   localparam int ROWS = 25;
   localparam int PHASES = 7;
   localparam int EVENTS_PER_PHASE = 44;

   // first block runs as rank 1 of 4 nodes, the tail as rank 15 of 16 with lock 0
   row_type script [ROWS] = '{
      '{OP_REQUEST, 4'd2,  32'd5,  1'b1, '{ACT_REPLY, 4'd2, 32'd0, 16'hFFFF, 1'b1}},
      '{OP_REPLY,   4'd9,  32'd0,  1'b0, NO_PACKET},
      '{OP_RELEASE, 4'd0,  32'd0,  1'b0, NO_PACKET},
      '{OP_ACQUIRE, 4'd0,  32'd0,  1'b1, '{ACT_BROADCAST, 4'd0, 32'd6, 16'hFFFF, 1'b1}},
      '{OP_REQUEST, 4'd3,  32'd6,  1'b0, NO_PACKET},
      '{OP_REQUEST, 4'd2,  32'd9,  1'b0, NO_PACKET},
      '{OP_REQUEST, 4'd0,  32'd6,  1'b1, '{ACT_REPLY, 4'd0, 32'd6, 16'hFFFF, 1'b1}},
      '{OP_REQUEST, 4'd1,  32'd20, 1'b1, '{ACT_REPLY, 4'd1, 32'd6, 16'hFFFF, 1'b1}},
      '{OP_REQUEST, 4'd15, 32'd30, 1'b1, '{ACT_REPLY, 4'd15, 32'd6, 16'hFFFF, 1'b1}},
      '{OP_REQUEST, 4'd0,  32'd4,  1'b1, '{ACT_REPLY, 4'd0, 32'd6, 16'hFFFF, 1'b1}},
      '{OP_REPLY,   4'd0,  32'd0,  1'b0, NO_PACKET},
      '{OP_ACQUIRE, 4'd7,  32'd77, 1'b0, NO_PACKET},
      '{OP_REPLY,   4'd0,  32'd0,  1'b0, NO_PACKET},
      '{OP_REPLY,   4'd0,  32'd0,  1'b0, NO_PACKET},
      '{OP_REPLY,   4'd0,  32'd0,  1'b1, '{ACT_GRANT, 4'd0, 32'd0, 16'h0000, 1'b1}},
      '{OP_REPLY,   4'd5,  32'd0,  1'b0, NO_PACKET},
      '{OP_RELEASE, 4'd0,  32'd0,  1'b0, NO_PACKET},
      '{OP_RELEASE, 4'd0,  32'd0,  1'b0, NO_PACKET},
      '{OP_RELEASE, 4'd0,  32'd0,  1'b0, NO_PACKET},
      '{OP_REQUEST, 4'd0,  CLK_MAX, 1'b0, NO_PACKET},
      '{OP_ACQUIRE, 4'd0,  32'd0,  1'b1, '{ACT_BROADCAST, 4'd0, CLK_MAX, 16'h0000, 1'b1}},
      '{OP_REQUEST, 4'd15, 32'd0,  1'b1, '{ACT_REPLY, 4'd15, CLK_MAX, 16'h0000, 1'b1}},
      '{OP_REQUEST, 4'd3,  CLK_MAX, 1'b1, '{ACT_REPLY, 4'd3, CLK_MAX, 16'h0000, 1'b1}},
      '{OP_ACQUIRE, 4'd0,  32'd0,  1'b1, '{ACT_BROADCAST, 4'd0, CLK_MAX, 16'h0000, 1'b1}},
      '{OP_RELEASE, 4'd0,  32'd0,  1'b0, NO_PACKET}
   };

   // node count 0 acts as 1, 17 and 31 act as 16
   phase_type plan [PHASES] = '{
      '{4'd0,  5'd16, 16'h0000, 1'b0},
      '{4'd15, 5'd1,  16'hFFFF, 1'b0},
      '{4'd1,  5'd3,  16'h1234, 1'b0},
      '{4'd6,  5'd0,  16'h5A3C, 1'b0},
      '{4'd3,  5'd31, 16'hA5C3, 1'b0},
      '{4'd9,  5'd17, 16'h0F0F, 1'b0},
      '{4'd12, 5'd6,  16'hF0F0, 1'b1}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   dmn_req_if req_ch ();
   dmn_rsp_if rsp_ch ();

   distributed_mutex_node_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // node state as the block should hold it
   logic [RANK_W-1:0]  cfg_rank = '0;
   logic [COUNT_W-1:0] cfg_count = NODE_COUNT_RESET;
   logic [LOCK_W-1:0]  cfg_lock = '0;
   logic               wants = 1'b0;
   logic [PCLK_W-1:0]  local_clk = '0;
   logic [PCLK_W-1:0]  high_clk = '0;
   logic [3:0]         replies_owed = '0;
   logic [15:0]        deferred = '0;

   packet_type outcome [$];
   packet_type pending_packets [$];
   int failures = 0;
   int taken = 0;
   bit held_off = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [COUNT_W-1:0] active_nodes();
      if (cfg_count == 0) return 5'd1;
      if (cfg_count > 5'd16) return 5'd16;
      return cfg_count;
   endfunction

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // compute the packets one accepted event emits, in order, into outcome
   task automatic apply_event(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] src,
                              input logic [PCLK_W-1:0] pclk);
      logic later;
      logic [COUNT_W-1:0] n;
      n = active_nodes();
      outcome.delete();
      case (op)
         OP_REQUEST: begin
            if (pclk > high_clk) high_clk = pclk;
            later = (pclk > local_clk) || (pclk == local_clk && src > cfg_rank);
            if (wants && later && src != cfg_rank && {1'b0, src} < n)
               deferred[src] = 1'b1;
            else
               outcome.push_back('{ACT_REPLY, src, local_clk, cfg_lock, 1'b0});
         end
         OP_REPLY: begin
            if (replies_owed != 0) begin
               replies_owed = replies_owed - 4'd1;
               if (replies_owed == 0) outcome.push_back('{ACT_GRANT, 4'd0, 32'd0, 16'd0, 1'b0});
            end
         end
         OP_ACQUIRE: begin
            wants = 1'b1;
            local_clk = (high_clk == CLK_MAX) ? CLK_MAX : high_clk + 32'd1;
            replies_owed = 4'(n - 5'd1);
            outcome.push_back('{ACT_BROADCAST, 4'd0, local_clk, cfg_lock, 1'b0});
            if (replies_owed == 0) outcome.push_back('{ACT_GRANT, 4'd0, 32'd0, 16'd0, 1'b0});
         end
         default: begin
            wants = 1'b0;
            replies_owed = '0;
            for (int i = 0; i < 16; i++)
               if (deferred[i]) outcome.push_back('{ACT_REPLY, 4'(i), local_clk, cfg_lock, 1'b0});
            deferred = '0;
         end
      endcase
      if (outcome.size() > 0) outcome[outcome.size()-1].last = 1'b1;
   endtask

   // offer one request; keep valid high when the next one follows at once
   task automatic offer_event(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] src,
                              input logic [PCLK_W-1:0] pclk, input bit typed,
                              input packet_type typed_pkt);
      int gap;
      gap = idle_span();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.source_node  <= src;
      req_ch.packet_clock <= pclk;
      do @(posedge clock); while (!req_ch.ready);
      apply_event(op, src, pclk);
      if (typed) pending_packets.push_back(typed_pkt);
      else foreach (outcome[i]) pending_packets.push_back(outcome[i]);
   endtask

   task automatic random_event(input bit wide);
      logic [OP_W-1:0]   op;
      logic [NODE_W-1:0] src;
      logic [PCLK_W-1:0] pclk;
      int roll;
      int pick;
      roll = $urandom_range(0, 99);
      if (!wants)
         op = roll < 45 ? OP_REQUEST : roll < 75 ? OP_ACQUIRE : roll < 85 ? OP_REPLY : OP_RELEASE;
      else if (replies_owed != 0)
         op = roll < 45 ? OP_REPLY : roll < 80 ? OP_REQUEST : roll < 88 ? OP_ACQUIRE : OP_RELEASE;
      else
         op = roll < 50 ? OP_REQUEST : roll < 85 ? OP_RELEASE : roll < 93 ? OP_REPLY : OP_ACQUIRE;
      src = NODE_W'($urandom_range(0, 15));
      pclk = $urandom;
      if (op == OP_REQUEST) begin
         // bias toward live peers and clocks close to our own to hit the tie rules
         if ($urandom_range(0, 3) != 0) src = NODE_W'($urandom_range(0, active_nodes() - 1));
         pick = $urandom_range(0, 99);
         if (wide && pick < 30) pclk = $urandom;
         else if (pick < 60) pclk = local_clk + $urandom_range(0, 2);
         else if (pick < 85) pclk = (local_clk > 3) ? local_clk - $urandom_range(1, 3) : local_clk;
         else pclk = $urandom_range(0, 64);
      end
      offer_event(op, src, pclk, 1'b0, NO_PACKET);
   endtask

   // hold the sender until every packet is in, then let the block settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_packets.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_node_config(input logic [RANK_W-1:0] rank,
                                  input logic [COUNT_W-1:0] count,
                                  input logic [LOCK_W-1:0] lock);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_OWN_RANK;
      csr_write_data <= {{(CSR_DATA_W-RANK_W){1'b0}}, rank};
      @(posedge clock);
      csr_index      <= CSR_NODE_COUNT;
      csr_write_data <= {{(CSR_DATA_W-COUNT_W){1'b0}}, count};
      @(posedge clock);
      csr_index      <= CSR_LOCK_ID;
      csr_write_data <= lock;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cfg_rank  = rank;
      cfg_count = count;
      cfg_lock  = lock;
   endtask

   // receiver: random stalls, plus one long hold-off to back the block up
   initial begin
      rsp_ch.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!held_off && taken >= 60) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (80) @(posedge clock);
         end else if ($urandom_range(0, 99) < 30) begin
            rsp_ch.ready <= 1'b0;
            repeat (idle_span() + 1) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      packet_type got;
      packet_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.action, rsp_ch.dest_node, rsp_ch.clock_stamp, rsp_ch.packet_lock,
                 rsp_ch.last};
         taken++;
         if (pending_packets.size() == 0) begin
            $display("%0t: unexpected packet act=%0d dest=%0d stamp=%h lock=%h last=%b",
                     $time, got.action, got.dest, got.stamp, got.lock, got.last);
            failures++;
         end else begin
            want = pending_packets.pop_front();
            if (got.action !== want.action || got.dest !== want.dest ||
                got.stamp !== want.stamp || got.lock !== want.lock || got.last !== want.last) begin
               $display("%0t: expected act=%0d dest=%0d stamp=%h lock=%h last=%b", $time,
                        want.action, want.dest, want.stamp, want.lock, want.last);
               $display("%0t: actual   act=%0d dest=%0d stamp=%h lock=%h last=%b", $time,
                        got.action, got.dest, got.stamp, got.lock, got.last);
               failures++;
            end
         end
      end
   end

   initial begin
      req_ch.valid        <= 1'b0;
      req_ch.operation    <= OP_REQUEST;
      req_ch.source_node  <= '0;
      req_ch.packet_clock <= '0;
      csr_write_en        <= 1'b0;
      csr_index           <= CSR_OWN_RANK;
      csr_write_data      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      set_node_config(4'd1, 5'd4, 16'hFFFF);
      for (int i = 0; i < HEAD_ROWS; i++)
         offer_event(script[i].op, script[i].src, script[i].pclk, script[i].typed,
                     script[i].pkt);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         set_node_config(plan[p].rank, plan[p].count, plan[p].lock);
         repeat (EVENTS_PER_PHASE) random_event(plan[p].wide);
         drain();
      end

      // saturate the clock last, it never comes back down
      set_node_config(4'd15, 5'd16, 16'h0000);
      for (int i = HEAD_ROWS; i < ROWS; i++)
         offer_event(script[i].op, script[i].src, script[i].pclk, script[i].typed,
                     script[i].pkt);
      drain();
      repeat (6) @(posedge clock);

      if (failures == 0 && pending_packets.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
